FILE: rtl/key_matrix_scan_debounce_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the key matrix scanner checker
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_SCAN_DEBOUNCE_MACROS_SVH
`define KEY_MATRIX_SCAN_DEBOUNCE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst is high
`define KMSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high
`define KMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kmsd_pkg.sv
// ----------------------------------------------------------------------------
// kmsd_pkg
// Shared constants, types and stream field layout of the key matrix scanner.
// ----------------------------------------------------------------------------
package kmsd_pkg;

  // Matrix geometry (per half)
  localparam int ROWS = 4;
  localparam int COLS = 8;

  // Key numbering: left keys, then right keys, then the boot key
  localparam int NKEYS    = 2 * ROWS * COLS + 1;
  localparam int BOOT_KEY = 2 * ROWS * COLS;
  localparam int KEY_W    = $clog2(NKEYS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int ACT_W    = 2 * ROWS;
  localparam int NSLOT    = 2 * COLS + 1;
  localparam int SLOT_W   = $clog2(NSLOT + 1);

  // Field widths
  localparam int LCOLS_W  = 9;
  localparam int RPORT_W  = 8;
  localparam int TIME_W   = 32;
  localparam int SPACE_W  = 8;
  localparam int OKEY_W   = 7;
  localparam int NROW_W   = 2;
  localparam int OACT_W   = 8;
  localparam int CFG_IDX_W = 8;
  localparam int BOOT_BIT = 8;

  // Input tdata layout
  localparam int IN_LCOLS_LSB = 0;
  localparam int IN_RPORT_LSB = IN_LCOLS_LSB + LCOLS_W;
  localparam int IN_TIME_LSB  = IN_RPORT_LSB + RPORT_W;
  localparam int IN_SPACE_LSB = IN_TIME_LSB + TIME_W;
  localparam int IN_DATA_W    = 64;

  // Output tdata layout
  localparam int OUT_KEY_LSB  = 0;
  localparam int OUT_TIME_LSB = OUT_KEY_LSB + OKEY_W;
  localparam int OUT_NROW_LSB = OUT_TIME_LSB + TIME_W;
  localparam int OUT_LED_LSB  = OUT_NROW_LSB + NROW_W;
  localparam int OUT_ACT_LSB  = OUT_LED_LSB + 1;
  localparam int OUT_DATA_W   = 56;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_PRESENT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PRESENT = 8'd1;

  // History entry bits
  localparam int HIST_ON      = 0;
  localparam int HIST_PRESSED = 1;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STATUS
  } state_t;

  // Write request into the key history memory
  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] addr;
    logic [1:0]       data;
  } hist_wr_t;

endpackage

FILE: rtl/key_matrix_scan_debounce.sv
// ----------------------------------------------------------------------------
// key_matrix_scan_debounce
// Scan tick handler for a split key matrix: debounces the current row of both
// halves (and the boot key on the last row), emits press/release events and a status.
// ----------------------------------------------------------------------------
// Pipeline: slots pass through the history memory read register and the
//   debounce stage to the output register; the status item follows the
//   last slot of the tick.
// Throughput: one key slot per cycle through the history memory read port
//   while m_tready does not stall the output register, 16 slots per tick
//   (17 on the last row). A skipped tick (queue nearly full) is accepted
//   without a scan.
// Reset: synchronous; clears row counter, activity flags and history.
module key_matrix_scan_debounce
  import kmsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Tick input: left_columns, right_port, timestamp, queue_space (LSB up)
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // Results: key_index, event_time, scan_row, right_led, row_activity
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,
  output logic [1:0]             m_tuser,   // kind
  output logic                   m_tlast,   // last
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data
);

  // Slot helpers: slot s covers column s/2, right half when s is odd,
  // the boot key at slot 2*COLS
  function automatic logic [31:0] slot_pos(logic [SLOT_W-1:0] s, logic [ROW_W-1:0] r);
    return 32'(r) * 32'(COLS) + 32'(s >> 1);
  endfunction

  function automatic logic slot_is_boot(logic [SLOT_W-1:0] s);
    return s == SLOT_W'(2 * COLS);
  endfunction

  function automatic logic [KEY_W-1:0] slot_key(logic [SLOT_W-1:0] s,
                                                logic [ROW_W-1:0] r);
    logic [31:0] p;
    p = slot_pos(s, r);
    if (slot_is_boot(s)) return KEY_W'(BOOT_KEY);
    else if (s[0])       return KEY_W'(ROWS * COLS) + KEY_W'(p);
    else                 return KEY_W'(p);
  endfunction

  function automatic logic slot_present(logic [SLOT_W-1:0] s, logic [ROW_W-1:0] r,
                                        logic [31:0] lm, logic [31:0] rm);
    logic [31:0] p;
    p = slot_pos(s, r);
    if (slot_is_boot(s)) return 1'b1;
    else if (p >= 32'd32) return 1'b0;
    else if (s[0]) return rm[p[4:0]];
    else return lm[p[4:0]];
  endfunction

  function automatic logic slot_on(logic [SLOT_W-1:0] s, logic [LCOLS_W-1:0] lc,
                                   logic [RPORT_W-1:0] rp);
    logic [31:0] c;
    c = 32'(s >> 1);
    if (slot_is_boot(s)) return lc[BOOT_BIT];
    else if (c >= 32'd8) return 1'b0;
    else if (s[0]) return rp[3'(c[2:0] + 3'd1)];
    else return lc[c[2:0]];
  endfunction

  // Configuration and persistent state
  logic [31:0]       left_key_present;
  logic [31:0]       right_key_present;
  logic [ROW_W-1:0]  row_counter;
  logic [ACT_W-1:0]  activity_flags;

  // Tick context
  logic [LCOLS_W-1:0] t_lcols;
  logic [RPORT_W-1:0] t_rport;
  logic [TIME_W-1:0]  t_time;
  logic [ROW_W-1:0]   t_cur;
  logic [ROW_W-1:0]   t_nxt;
  logic               t_led;

  // Slot pipeline
  state_t            state, state_next;
  logic [SLOT_W-1:0] issue_slot;
  logic              s2_valid;
  logic [SLOT_W-1:0] s2_slot;

  // Output register
  logic              o_valid;
  kind_t             o_kind;
  logic [OKEY_W-1:0] o_key;
  logic [TIME_W-1:0] o_time;
  logic [NROW_W-1:0] o_nrow;
  logic              o_led;
  logic [OACT_W-1:0] o_act;
  logic              o_last;

  // Combinational
  logic [LCOLS_W-1:0] in_lcols;
  logic [RPORT_W-1:0] in_rport;
  logic [TIME_W-1:0]  in_time;
  logic [SPACE_W-1:0] in_space;
  logic               space_ok;
  logic [ROW_W-1:0]   row_next;
  logic [SLOT_W-1:0]  nslots;
  logic [KEY_W-1:0]   s2_key;
  logic               s2_present;
  logic               s2_on;
  logic               s2_boot;
  logic [1:0]         hist_old;
  logic [1:0]         hist_now;
  logic               s2_press;
  logic               s2_release;
  logic               s2_emit;
  logic               out_free;
  logic               s2_done;
  logic               advance;
  logic [ACT_W-1:0]   act_bit;
  logic [ACT_W-1:0]   act_clr;
  logic               tick_start;
  logic               issue;
  logic               commit;
  logic               load_ev;
  logic               load_st;
  hist_wr_t           hist_wr;

  // Input field unpacking
  assign in_lcols = s_tdata[IN_LCOLS_LSB +: LCOLS_W];
  assign in_rport = s_tdata[IN_RPORT_LSB +: RPORT_W];
  assign in_time  = s_tdata[IN_TIME_LSB +: TIME_W];
  assign in_space = s_tdata[IN_SPACE_LSB +: SPACE_W];
  assign space_ok = in_space >= SPACE_W'(COLS);

  // Row sequencing and slot count of the running tick
  assign row_next = (row_counter == ROW_W'(ROWS - 1)) ? '0 : row_counter + ROW_W'(1);
  assign nslots   = (t_cur == ROW_W'(ROWS - 1)) ? SLOT_W'(2 * COLS + 1)
                                                : SLOT_W'(2 * COLS);
  assign act_clr  = (ACT_W'(1) << row_counter) | (ACT_W'(1) << (32'(row_counter) + 32'(ROWS)));

  // Debounce stage: history entry from memory, sample from the tick
  assign s2_key     = slot_key(s2_slot, t_cur);
  assign s2_present = slot_present(s2_slot, t_cur, left_key_present, right_key_present);
  assign s2_on      = slot_on(s2_slot, t_lcols, t_rport);
  assign s2_boot    = slot_is_boot(s2_slot);
  assign hist_now   = {hist_old[HIST_ON] & s2_on, s2_on};
  assign s2_press   = !hist_old[HIST_PRESSED] && hist_now[HIST_PRESSED];
  assign s2_release = hist_old[HIST_PRESSED] && !hist_now[HIST_PRESSED];
  assign s2_emit    = s2_valid && s2_present && (s2_press || s2_release);
  assign out_free   = !o_valid || m_tready;
  assign s2_done    = !s2_emit || out_free;
  assign advance    = !s2_valid || s2_done;
  assign act_bit    = (s2_slot[0] && !s2_boot)
                    ? (ACT_W'(1) << (32'(t_cur) + 32'(ROWS)))
                    : (ACT_W'(1) << t_cur);

  // History memory
  assign hist_wr.en   = commit;
  assign hist_wr.addr = s2_key;
  assign hist_wr.data = hist_now;

  kmsd_hist_mem u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (issue),
    .rd_addr (slot_key(issue_slot, t_cur)),
    .rd_data (hist_old),
    .wr      (hist_wr)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && space_ok) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (advance && issue_slot == nslots) state_next = ST_STATUS;
      end
      ST_STATUS: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs per state
  always_comb begin
    s_tready   = 1'b0;
    tick_start = 1'b0;
    issue      = 1'b0;
    commit     = 1'b0;
    load_ev    = 1'b0;
    load_st    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = !rst;
        tick_start = s_tvalid && space_ok;
      end
      ST_SCAN: begin
        issue   = advance && (issue_slot < nslots);
        commit  = s2_valid && s2_present && s2_done;
        load_ev = s2_emit && out_free;
      end
      ST_STATUS: begin
        load_st = out_free;
      end
      default: ;
    endcase
  end

  assign cfg_ready = !rst;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      row_counter       <= '0;
      activity_flags    <= '0;
      issue_slot        <= '0;
      s2_valid          <= 1'b0;
      o_valid           <= 1'b0;
      left_key_present  <= '1;
      right_key_present <= '1;
    end else begin
      state <= state_next;

      // Configuration transaction
      if (cfg_valid) begin
        case (cfg_index)
          REG_LEFT_PRESENT:  left_key_present  <= cfg_data;
          REG_RIGHT_PRESENT: right_key_present <= cfg_data;
          default: ;
        endcase
      end

      // Tick start: advance row, clear this row's flags
      if (tick_start) begin
        row_counter    <= row_next;
        activity_flags <= activity_flags & ~act_clr;
        issue_slot     <= '0;
        s2_valid       <= 1'b0;
      end

      // Slot pipeline
      if (state == ST_SCAN) begin
        if (commit && hist_now[HIST_PRESSED]) begin
          activity_flags <= activity_flags | act_bit;
        end
        if (advance) begin
          s2_valid <= issue;
        end
        if (issue) begin
          issue_slot <= issue_slot + SLOT_W'(1);
        end
      end

      // Output register valid
      if (load_ev || load_st) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (tick_start) begin
      t_lcols <= in_lcols;
      t_rport <= in_rport;
      t_time  <= in_time;
      t_cur   <= row_counter;
      t_nxt   <= row_next;
      t_led   <= |activity_flags[ACT_W-1:ROWS];
    end
    if (issue) begin
      s2_slot <= issue_slot;
    end
    if (load_ev) begin
      o_kind <= s2_press ? KIND_PRESS : KIND_RELEASE;
      o_key  <= OKEY_W'(s2_key);
      o_time <= t_time;
      o_nrow <= NROW_W'(t_nxt);
      o_led  <= t_led;
      o_act  <= '0;
      o_last <= 1'b0;
    end else if (load_st) begin
      o_kind <= KIND_STATUS;
      o_key  <= '0;
      o_time <= t_time;
      o_nrow <= NROW_W'(t_nxt);
      o_led  <= t_led;
      o_act  <= OACT_W'(activity_flags);
      o_last <= 1'b1;
    end
  end

  // Result packing
  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_KEY_LSB +: OKEY_W]  = o_key;
    m_tdata[OUT_TIME_LSB +: TIME_W] = o_time;
    m_tdata[OUT_NROW_LSB +: NROW_W] = o_nrow;
    m_tdata[OUT_LED_LSB]            = o_led;
    m_tdata[OUT_ACT_LSB +: OACT_W]  = o_act;
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;

endmodule

FILE: rtl/kmsd_hist_mem.sv
// ----------------------------------------------------------------------------
// kmsd_hist_mem
// Key history store: one 2-bit entry per key, registered read, one write
// port. Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module kmsd_hist_mem
  import kmsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [KEY_W-1:0] rd_addr,
  output logic [1:0]       rd_data,
  input  hist_wr_t         wr
);

  logic [1:0]       mem [NKEYS];
  logic [NKEYS-1:0] vld;
  logic [1:0]       rd_raw;
  logic             rd_vld;

  // Storage array and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : 2'b00;

endmodule

FILE: rtl/kmsd_checker.sv
// ----------------------------------------------------------------------------
// kmsd_checker
// Port-level checks of the key matrix scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_matrix_scan_debounce_macros.svh"

module kmsd_checker
  import kmsd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]            m_tuser,
  input logic                  m_tlast
);

  // A new tick is taken only once its predecessor's events have all drained
  `KMSD_ASSERT_SAME(a_tick_after_events, s_tvalid && s_tready, !m_tvalid || m_tlast, "tick accepted with an event pending")

  // Status item: status kind, zero key index
  `KMSD_ASSERT_SAME(a_status_fields, m_tvalid && m_tlast, (m_tuser == KIND_STATUS) && (m_tdata[OUT_KEY_LSB +: OKEY_W] == '0), "bad status item")

  // Event items carry press or release and no activity bits
  `KMSD_ASSERT_SAME(a_event_fields, m_tvalid && !m_tlast, (m_tuser != KIND_STATUS) && (m_tdata[OUT_ACT_LSB +: OACT_W] == '0), "bad event item")

  // Stalled result holds
  `KMSD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

endmodule

bind key_matrix_scan_debounce kmsd_checker u_kmsd_checker (.*);
